// ----- rtl/zdf_pkg.sv -----
// ----------------------------------------------------------------------------
// zdf_pkg
// Shared types, constants and helper functions for the four-pole ladder filter.
// ----------------------------------------------------------------------------
package zdf_pkg;

  // sample and coefficient formats
  localparam int SAMPLE_W  = 24;
  localparam int CUT_W     = 15;
  localparam int RES_W     = 16;
  localparam int K_W       = RES_W + 10;
  localparam int X_W       = SAMPLE_W + 1;
  localparam int FRAC      = 24;
  localparam int COEF_W    = FRAC + 1;
  localparam int TAB_W     = 31;

  // tan table
  localparam int TAN_DEPTH = 1024;
  localparam int IDX_W     = $clog2(TAN_DEPTH);
  localparam int ADDR_W    = IDX_W + 1;

  // input queue
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // reciprocal unit: 2^48 / d with d >= 2^24 gives at most 25 quotient bits
  localparam int QUO_W   = COEF_W;
  localparam int STEP_W  = $clog2(QUO_W);
  localparam int DIV_W   = 32;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] GMAX   = 64'd2147483647;
  localparam logic [2:0]  MODE_RESET = 3'd1;

  typedef enum logic [2:0] {
    MODE_LP2 = 3'd0,
    MODE_LP4 = 3'd1,
    MODE_BP2 = 3'd2,
    MODE_BP4 = 3'd3,
    MODE_HP2 = 3'd4,
    MODE_HP4 = 3'd5
  } mode_t;

  // classified item handed from front to back
  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic [K_W-1:0]        k;
    logic [IDX_W-1:0]      idx;
    logic [CUT_W-1:0]      fr;
  } item_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUO_W-1:0]  quo;
  } div_rsp_t;

  typedef logic [TAB_W-1:0] tan_rom_t [0:TAN_DEPTH];

  // saturate to the 32-bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -48'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // product back to q.24, round to nearest with ties up
  function automatic logic signed [39:0] qrnd(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd8388608;
    return t[63:24];
  endfunction

  // elaboration-time shift-subtract divide for the table build
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // tan(pi/2 * i/depth) in q.24 from q2.30 taylor series
  function automatic tan_rom_t build_tan();
    tan_rom_t           tab;
    logic [63:0]        x, x2, ts, tc, q;
    logic signed [63:0] s, c, t;
    for (int i = 0; i <= TAN_DEPTH; i++) begin
      x  = (PI_Q30 * 64'(i)) / (2 * TAN_DEPTH);
      x2 = (x * x) >> 30;
      ts = x;
      tc = 64'd1 << 30;
      s  = signed'(ts);
      c  = signed'(tc);
      for (int k = 1; k <= 7; k++) begin
        ts = (ts * x2) >> 30;
        tc = (tc * x2) >> 30;
        case (k)
          1: begin ts = ts / 6;   tc = tc / 2;   end
          2: begin ts = ts / 20;  tc = tc / 12;  end
          3: begin ts = ts / 42;  tc = tc / 30;  end
          4: begin ts = ts / 72;  tc = tc / 56;  end
          5: begin ts = ts / 110; tc = tc / 90;  end
          6: begin ts = ts / 156; tc = tc / 132; end
          default: begin ts = ts / 210; tc = tc / 182; end
        endcase
        if ((k % 2) == 1) begin
          s = s - signed'(ts);
          c = c - signed'(tc);
        end else begin
          s = s + signed'(ts);
          c = c + signed'(tc);
        end
      end
      if (s < 0) s = 0;
      if (c <= 0) begin
        t = signed'(GMAX);
      end else begin
        q = udiv64(unsigned'(s) << FRAC, unsigned'(c));
        t = (q > GMAX) ? signed'(GMAX) : signed'(q);
      end
      tab[i] = t[TAB_W-1:0];
    end
    return tab;
  endfunction

endpackage

// ----- rtl/zdf_ladder_multimode_filter_core.sv -----
// ----------------------------------------------------------------------------
// zdf_ladder_multimode_filter_core
// Four-pole zero-delay-feedback ladder filter with six selectable responses.
// ----------------------------------------------------------------------------
//  channel | ports                                         | handshake
//  input   | in_sample_in, in_cutoff, in_resonance         | in_push / in_full
//  result  | out_sample_out                                | out_pop / out_empty
//  config  | cfg_mode                                      | cfg_valid / cfg_ready
//
//  in the back end each sample runs two 25-step reciprocals
//  and 17 operations on one shared 32x32 multiplier, each issue plus writeback.
//  a two-entry queue takes new samples while the back end works.
//  reset is synchronous; filter states clear to zero and mode returns to lp4.
//  a result waiting in the output register stalls the back end; the input
//  stalls once the two-entry queue is full.
// ----------------------------------------------------------------------------
module zdf_ladder_multimode_filter_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [zdf_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic [zdf_pkg::CUT_W-1:0]           in_cutoff,
  input  logic [zdf_pkg::RES_W-1:0]           in_resonance,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [zdf_pkg::SAMPLE_W-1:0] out_sample_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [2:0]                          cfg_mode
);
  import zdf_pkg::*;

  logic [2:0] mode_q_r;
  logic       item_valid, item_pop;
  item_t      item;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  // mode register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_q_r <= MODE_RESET;
    end else begin
      if (cfg_valid && cfg_ready) mode_q_r <= cfg_mode;
    end
  end

  zdf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_sample_in (in_sample_in),
    .in_cutoff    (in_cutoff),
    .in_resonance (in_resonance),
    .item_valid   (item_valid),
    .item         (item),
    .item_pop     (item_pop)
  );

  zdf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  zdf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .mode           (mode_q_r),
    .item_valid     (item_valid),
    .item           (item),
    .item_pop       (item_pop),
    .div_req        (div_req),
    .div_rsp        (div_rsp),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_sample_out (out_sample_out)
  );

endmodule

// ----- rtl/zdf_front.sv -----
// ----------------------------------------------------------------------------
// zdf_front
// Takes input transactions, converts them to internal formats and queues them.
// ----------------------------------------------------------------------------
module zdf_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [zdf_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic [zdf_pkg::CUT_W-1:0]           in_cutoff,
  input  logic [zdf_pkg::RES_W-1:0]           in_resonance,
  output logic                                item_valid,
  output zdf_pkg::item_t                      item,
  input  logic                                item_pop
);
  import zdf_pkg::*;

  item_t                 mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [CUT_W+IDX_W-1:0] pos;
  item_t                 cls;
  logic                  wr_en, rd_en;

  // classify: q.24 sample, feedback gain, table index and fraction
  always_comb begin
    pos     = {in_cutoff, {IDX_W{1'b0}}};
    cls.x   = {in_sample_in, 1'b0};
    cls.k   = {in_resonance, 10'b0};
    cls.idx = pos[CUT_W+IDX_W-1:CUT_W];
    cls.fr  = pos[CUT_W-1:0];
  end

  assign in_full    = (cnt_r == CNT_W'(FIFO_DEPTH));
  assign wr_en      = in_push && !in_full;
  assign rd_en      = item_pop && item_valid;
  assign item_valid = (cnt_r != '0);
  assign item       = mem_r[rd_ptr_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (rd_en) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/zdf_div.sv -----
// ----------------------------------------------------------------------------
// zdf_div
// Reciprocal unit: 2^48 / divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module zdf_div (
  input  logic               clk,
  input  logic               rst_n,
  input  zdf_pkg::div_req_t  req,
  output zdf_pkg::div_rsp_t  rsp
);
  import zdf_pkg::*;

  logic               busy_r, done_r;
  logic [STEP_W-1:0]  cnt_r;
  logic [DIV_W-1:0]   rem_r, d_r;
  logic [QUO_W-1:0]   q_r;
  logic [DIV_W:0]     trial;
  logic               ge;

  // one restoring step
  assign trial = {rem_r, 1'b0};
  assign ge    = (trial >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEP_W'(QUO_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: remainder starts at 2^23, all numerator bits below are zero
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= DIV_W'(1) << (FRAC - 1);
      d_r   <= req.divisor;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? DIV_W'(trial - {1'b0, d_r}) : trial[DIV_W-1:0];
      q_r   <= {q_r[QUO_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = q_r;

endmodule

// ----- rtl/zdf_back.sv -----
// ----------------------------------------------------------------------------
// zdf_back
// Filter sequencer: table lookup, coefficients, four one-pole stages, mix.
// ----------------------------------------------------------------------------
module zdf_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [2:0]                           mode,
  input  logic                                 item_valid,
  input  zdf_pkg::item_t                       item,
  output logic                                 item_pop,
  output zdf_pkg::div_req_t                    div_req,
  input  zdf_pkg::div_rsp_t                    div_rsp,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic signed [zdf_pkg::SAMPLE_W-1:0]  out_sample_out
);
  import zdf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ROM1, ST_ROM2, ST_INTERP, ST_DIV1, ST_MUL, ST_DIV2, ST_MIX, ST_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_B3, OP_B2, OP_B1, OP_A2, OP_A3, OP_GM, OP_FB,
    OP_S1, OP_S2, OP_S3, OP_S4, OP_KS, OP_U,
    OP_F1, OP_F2, OP_F3, OP_F4
  } op_t;

  localparam tan_rom_t TAN_ROM = build_tan();
  localparam logic [COEF_W-1:0] ONE_Q = COEF_W'(1) << FRAC;

  state_t                   state_r;
  op_t                      op_r;
  logic                     ph_r;
  item_t                    item_r;
  logic [ADDR_W-1:0]        rom_addr;
  logic [TAB_W-1:0]         rom_q_r, t0_r;
  logic signed [31:0]       mul_a, mul_b;
  logic signed [63:0]       prod_r;
  logic signed [39:0]       qv;
  logic [COEF_W-1:0]        beta4_r, beta3_r, beta2_r, beta1_r, alpha_r, tmp_r, alpha0_r;
  logic signed [35:0]       acc_r;
  logic signed [31:0]       sigma_r, v_r, u_r, stin_r;
  logic signed [31:0]       lp_r [4];
  logic signed [31:0]       z_r [4];
  logic [1:0]               sidx;
  logic signed [31:0]       z_sel, lp_new, z_new;
  logic signed [35:0]       acc_new;
  logic signed [32:0]       diff;
  logic [32:0]              g_sum;
  logic [DIV_W-1:0]         g_div;
  logic signed [37:0]       y, l1, l2, l3, l4, ue;
  logic signed [37:0]       yr;
  logic signed [SAMPLE_W-1:0] res_r, res_sat;
  logic                     out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;

  // table read, registered
  always_comb begin
    if (state_r == ST_IDLE) begin
      rom_addr = {1'b0, item.idx};
    end else begin
      rom_addr = {1'b0, item_r.idx} + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rom_q_r <= TAN_ROM[rom_addr];
  end

  // interpolation slope, negative steps clamp to zero
  assign diff = 33'(signed'({1'b0, rom_q_r})) - 33'(signed'({1'b0, t0_r}));

  // interpolated g, capped at gmax, plus one for the first reciprocal
  always_comb begin
    g_sum = {2'b0, t0_r} + {1'b0, prod_r[46:15]};
    if (g_sum > 33'(GMAX)) g_sum = 33'(GMAX);
    g_div = DIV_W'(g_sum) + DIV_W'(ONE_Q);
  end

  // stage index of the current stage op
  always_comb begin
    unique case (op_r)
      OP_F2:   sidx = 2'd1;
      OP_F3:   sidx = 2'd2;
      OP_F4:   sidx = 2'd3;
      default: sidx = 2'd0;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_ROM2) begin
      mul_a = diff[32] ? 32'sd0 : diff[31:0];
      mul_b = signed'({17'b0, item_r.fr});
    end else if (state_r == ST_MUL && !ph_r) begin
      unique case (op_r)
        OP_B3: begin mul_a = signed'(32'(beta4_r)); mul_b = signed'(32'(alpha_r)); end
        OP_B2: begin mul_a = signed'(32'(beta3_r)); mul_b = signed'(32'(alpha_r)); end
        OP_B1: begin mul_a = signed'(32'(beta2_r)); mul_b = signed'(32'(alpha_r)); end
        OP_A2: begin mul_a = signed'(32'(alpha_r)); mul_b = signed'(32'(alpha_r)); end
        OP_A3, OP_GM: begin
          mul_a = signed'(32'(tmp_r));
          mul_b = signed'(32'(alpha_r));
        end
        OP_FB: begin mul_a = signed'(32'(tmp_r)); mul_b = signed'(32'(item_r.k)); end
        OP_S1: begin mul_a = z_r[0]; mul_b = signed'(32'(beta1_r)); end
        OP_S2: begin mul_a = z_r[1]; mul_b = signed'(32'(beta2_r)); end
        OP_S3: begin mul_a = z_r[2]; mul_b = signed'(32'(beta3_r)); end
        OP_S4: begin mul_a = z_r[3]; mul_b = signed'(32'(beta4_r)); end
        OP_KS: begin mul_a = signed'(32'(item_r.k)); mul_b = sigma_r; end
        OP_U:  begin mul_a = v_r; mul_b = signed'(32'(alpha0_r)); end
        default: begin
          mul_a = sat32(48'(stin_r) - 48'(z_r[sidx]));
          mul_b = signed'(32'(alpha_r));
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign qv = qrnd(prod_r);

  // one-pole stage update and sigma accumulate
  always_comb begin
    z_sel   = z_r[sidx];
    lp_new  = sat32(48'(qv) + 48'(z_sel));
    z_new   = sat32(48'(qv) + 48'(lp_new));
    acc_new = acc_r + 36'(qv);
  end

  // mode mix, round to q1.23 and saturate
  always_comb begin
    l1 = 38'(lp_r[0]);
    l2 = 38'(lp_r[1]);
    l3 = 38'(lp_r[2]);
    l4 = 38'(lp_r[3]);
    ue = 38'(u_r);
    unique case (mode)
      MODE_LP2: y = l2;
      MODE_LP4: y = l4;
      MODE_BP2: y = (l1 <<< 1) - (l2 <<< 1);
      MODE_BP4: y = (l2 <<< 2) - (l3 <<< 3) + (l4 <<< 2);
      MODE_HP2: y = ue - (l1 <<< 1) + l2;
      MODE_HP4: y = ue - (l1 <<< 2) + (l2 <<< 2) + (l2 <<< 1) - (l3 <<< 2) + l4;
      default:  y = '0;
    endcase
    yr = (y + 38'sd1) >>> 1;
    if (yr > 38'sd8388607) begin
      res_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (yr < -38'sd8388608) begin
      res_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      res_sat = yr[SAMPLE_W-1:0];
    end
  end

  assign item_pop = (state_r == ST_IDLE) && item_valid;

  // reciprocal requests
  always_comb begin
    div_req.start   = 1'b0;
    div_req.divisor = g_div;
    if (state_r == ST_INTERP) begin
      div_req.start = 1'b1;
    end else if (state_r == ST_MUL && ph_r && op_r == OP_FB) begin
      div_req.start   = 1'b1;
      div_req.divisor = DIV_W'(ONE_Q) + DIV_W'({qv[28:0], 2'b00});
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_B3;
      ph_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) z_r[i] <= '0;
    end else begin
      if (out_pop && out_valid_r && state_r != ST_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (item_valid) begin
            item_r  <= item;
            state_r <= ST_ROM1;
          end
        end
        ST_ROM1: begin
          t0_r    <= rom_q_r;
          state_r <= ST_ROM2;
        end
        ST_ROM2: state_r <= ST_INTERP;
        ST_INTERP: state_r <= ST_DIV1;
        ST_DIV1: begin
          if (div_rsp.done) begin
            beta4_r <= div_rsp.quo;
            alpha_r <= ONE_Q - div_rsp.quo;
            op_r    <= OP_B3;
            ph_r    <= 1'b0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (!ph_r) begin
            ph_r <= 1'b1;
          end else begin
            ph_r <= 1'b0;
            op_r <= (op_r == OP_F4) ? OP_B3 : op_t'(op_r + 5'd1);
            unique case (op_r)
              OP_B3: beta3_r <= qv[COEF_W-1:0];
              OP_B2: beta2_r <= qv[COEF_W-1:0];
              OP_B1: beta1_r <= qv[COEF_W-1:0];
              OP_A2, OP_A3, OP_GM: tmp_r <= qv[COEF_W-1:0];
              OP_FB: state_r <= ST_DIV2;
              OP_S1: acc_r <= 36'(qv);
              OP_S2, OP_S3: acc_r <= acc_new;
              OP_S4: sigma_r <= sat32(48'(acc_new));
              OP_KS: v_r <= sat32(48'(item_r.x) - 48'(qv));
              OP_U: begin
                u_r    <= sat32(48'(qv));
                stin_r <= sat32(48'(qv));
              end
              default: begin
                lp_r[sidx] <= lp_new;
                z_r[sidx]  <= z_new;
                stin_r     <= lp_new;
                if (op_r == OP_F4) state_r <= ST_MIX;
              end
            endcase
          end
        end
        ST_DIV2: begin
          if (div_rsp.done) begin
            alpha0_r <= div_rsp.quo;
            state_r  <= ST_MUL;
          end
        end
        ST_MIX: begin
          res_r   <= res_sat;
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_r || out_pop) begin
            out_sample_r <= res_r;
            out_valid_r  <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_sample_out = out_sample_r;

endmodule

// ----- rtl/zdf_checker.sv -----
// ----------------------------------------------------------------------------
// zdf_checker
// Port-level checks on the filter core, attached by bind.
// ----------------------------------------------------------------------------
module zdf_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_full,
  input logic                                out_empty,
  input logic                                out_pop,
  input logic signed [zdf_pkg::SAMPLE_W-1:0] out_sample_out,
  input logic                                cfg_ready
);

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending after reset");

  // reset leaves the input queue open
  a_reset_open: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");

  // a waiting result stays and holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_sample_out)))
    else $error("result changed while waiting");

  // configuration port never stalls
  a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cfg_ready)
    else $error("config port stalled");

endmodule

bind zdf_ladder_multimode_filter_core zdf_checker u_zdf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_full        (in_full),
  .out_empty      (out_empty),
  .out_pop        (out_pop),
  .out_sample_out (out_sample_out),
  .cfg_ready      (cfg_ready)
);

// ----- tb/sv/tb_zdf_ladder_multimode_filter_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_zdf_ladder_multimode_filter_core
// Self-checking bench for the ladder filter core. A clocked driver feeds
// samples from a pending queue, and a clocked monitor pops results and checks
// them against a bit-exact fixed-point filter model. The run steps through
// every mode, with random idle bursts on both ports and one long output stall.
// ----------------------------------------------------------------------------
module tb_zdf_ladder_multimode_filter_core;
  import zdf_pkg::*;

  localparam logic [2:0] MODE_OFF6 = 3'd6;
  localparam logic [2:0] MODE_OFF7 = 3'd7;
  localparam int DEPTH = 1024;
  localparam int ITEMS_PER_PHASE = 170;
  localparam int SETTLE_CYCLES = 200;

  typedef struct {
    logic signed [23:0] smp;
    logic [14:0]        cut;
    logic [15:0]        res;
  } sample_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic signed [23:0] in_sample_in = '0;
  logic [14:0] in_cutoff = '0;
  logic [15:0] in_resonance = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic signed [23:0] out_sample_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_mode = '0;

  sample_item_t pending_samples[$];
  logic signed [23:0] expected_outputs[$];

  // filter model state
  longint tan_lut[0:DEPTH];
  longint integ1, integ2, integ3, integ4;
  logic [2:0] filter_mode;

  int err_count = 0;
  int checked = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int drv_idle = 0;
  int mon_idle = 0;
  int hold_cnt = 0;

  zdf_ladder_multimode_filter_core dut (.*);

  always #5 clk = ~clk;

  function automatic longint sat_q4(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mul_q24(longint a, longint b);
    return (a * b + 64'sd8388608) >>> 24;
  endfunction

  // tan table from integer taylor series, q2.30 inside, q.24 out
  task automatic fill_tan_lut();
    longint unsigned x, x2, ts, tc, q;
    longint s, c;
    for (int i = 0; i <= DEPTH; i++) begin
      x  = (64'd3373259426 * longint'(i)) / (2 * DEPTH);
      x2 = (x * x) >> 30;
      ts = x;
      tc = 64'd1 << 30;
      s  = longint'(ts);
      c  = longint'(tc);
      for (int k = 1; k <= 7; k++) begin
        ts = ((ts * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
        tc = ((tc * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
        if (k % 2 == 1) begin
          s -= longint'(ts);
          c -= longint'(tc);
        end else begin
          s += longint'(ts);
          c += longint'(tc);
        end
      end
      if (s < 0) s = 0;
      if (c <= 0) begin
        tan_lut[i] = 64'sd2147483647;
      end else begin
        q = (longint'(s) << 24) / longint'(c);
        tan_lut[i] = (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
      end
    end
  endtask

  function automatic longint ladder_pole(longint vin, ref longint z, input longint a);
    longint vn, lp;
    vn = mul_q24(sat_q4(vin - z), a);
    lp = sat_q4(vn + z);
    z = sat_q4(vn + lp);
    return lp;
  endfunction

  // one filter step, updates the model integrators
  function automatic logic signed [23:0] filter_sample(sample_item_t it);
    longint x, kk, pos, idx, fr, diff, g, b4, a, b3, b2, b1, a2, gam, fb, a0;
    longint sig, u, l1, l2, l3, l4, y, r;
    x  = longint'(it.smp) * 2;
    kk = longint'(it.res) << 10;
    pos = longint'(it.cut) * DEPTH;
    idx = pos >> 15;
    fr  = pos & 32767;
    if (idx >= DEPTH) begin
      idx = DEPTH - 1;
      fr = 32767;
    end
    diff = tan_lut[idx + 1] - tan_lut[idx];
    if (diff < 0) diff = 0;
    g = tan_lut[idx] + ((diff * fr) >>> 15);
    if (g > 64'sd2147483647) g = 64'sd2147483647;
    b4 = (64'sd1 << 48) / ((64'sd1 << 24) + g);
    a  = (64'sd1 << 24) - b4;
    b3 = mul_q24(b4, a);
    b2 = mul_q24(b3, a);
    b1 = mul_q24(b2, a);
    a2 = mul_q24(a, a);
    gam = mul_q24(mul_q24(a2, a), a);
    fb = mul_q24(gam, kk) * 4;
    a0 = (64'sd1 << 48) / ((64'sd1 << 24) + fb);
    sig = sat_q4(mul_q24(integ1, b1) + mul_q24(integ2, b2) +
                 mul_q24(integ3, b3) + mul_q24(integ4, b4));
    u = sat_q4(mul_q24(sat_q4(x - mul_q24(kk, sig)), a0));
    l1 = ladder_pole(u, integ1, a);
    l2 = ladder_pole(l1, integ2, a);
    l3 = ladder_pole(l2, integ3, a);
    l4 = ladder_pole(l3, integ4, a);
    case (filter_mode)
      MODE_LP2: y = l2;
      MODE_LP4: y = l4;
      MODE_BP2: y = 2 * l1 - 2 * l2;
      MODE_BP4: y = 4 * l2 - 8 * l3 + 4 * l4;
      MODE_HP2: y = u - 2 * l1 + l2;
      MODE_HP4: y = u - 4 * l1 + 6 * l2 - 4 * l3 + l4;
      default:  y = 0;
    endcase
    r = (y + 1) >>> 1;
    if (r > 64'sd8388607) r = 64'sd8388607;
    if (r < -64'sd8388608) r = -64'sd8388608;
    return r[23:0];
  endfunction

  task automatic report_mismatch(string what, logic signed [23:0] got,
                                 logic signed [23:0] want);
    err_count++;
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
  endtask

  // driver: offer pending samples, predict on each accepted transaction
  always @(posedge clk) begin
    logic nxt;
    nxt = 1'b0;
    if (rst_n) begin
      if (in_push && !in_full) begin
        expected_outputs.push_back(filter_sample(pending_samples[0]));
        void'(pending_samples.pop_front());
      end
      if (drv_idle > 0) begin
        drv_idle--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        drv_idle = $urandom_range(0, 4);
      end else begin
        nxt = pending_samples.size() > 0;
      end
      in_push <= nxt;
      if (nxt) begin
        in_sample_in <= pending_samples[0].smp;
        in_cutoff    <= pending_samples[0].cut;
        in_resonance <= pending_samples[0].res;
      end
    end
  end

  // monitor: pop results and compare against the oldest prediction
  always @(posedge clk) begin
    logic nxt;
    nxt = 1'b0;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        checked++;
        if (expected_outputs.size() == 0) begin
          report_mismatch("unexpected transaction", out_sample_out, '0);
        end else begin
          if (out_sample_out !== expected_outputs[0])
            report_mismatch("sample_out", out_sample_out, expected_outputs[0]);
          void'(expected_outputs.pop_front());
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
      end else if (mon_idle > 0) begin
        mon_idle--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        mon_idle = $urandom_range(0, 4);
      end else begin
        nxt = 1'b1;
      end
      out_pop <= nxt;
    end
  end

  task automatic add_sample(logic signed [23:0] s, logic [14:0] c, logic [15:0] r);
    sample_item_t it;
    it.smp = s;
    it.cut = c;
    it.res = r;
    pending_samples.push_back(it);
  endtask

  task automatic add_random_sample();
    logic signed [23:0] s;
    logic [14:0] c;
    logic [15:0] r;
    case ($urandom_range(0, 9))
      0: s = 24'sh7FFFFF;
      1: s = -24'sh800000;
      default: s = 24'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0: c = 15'h7FFF;
      1: c = 15'($urandom_range(0, 40));
      default: c = 15'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0: r = 16'hFFFF;
      1: r = 16'h0000;
      default: r = 16'($urandom);
    endcase
    add_sample(s, c, r);
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || expected_outputs.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(logic [2:0] m);
    cfg_valid <= 1'b1;
    cfg_mode  <= m;
    do @(posedge clk); while (!cfg_ready);
    filter_mode = m;
    cfg_valid <= 1'b0;
  endtask

  // run limit
  initial begin
    #20ms;
    $display("timeout at %0t", $time);
    $display("[zdf_ladder_multimode_filter_core] ERROR");
    $finish;
  end

  initial begin
    logic [2:0] phases[9];
    phases = '{MODE_LP4, MODE_LP2, MODE_BP2, MODE_BP4, MODE_HP2, MODE_HP4,
               MODE_OFF6, MODE_OFF7, MODE_LP4};
    fill_tan_lut();
    integ1 = 0;
    integ2 = 0;
    integ3 = 0;
    integ4 = 0;
    filter_mode = MODE_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed extremes under the reset mode
    add_sample(24'sh7FFFFF, 15'd0, 16'd0);
    add_sample(-24'sh800000, 15'd0, 16'hFFFF);
    add_sample(24'sh7FFFFF, 15'h7FFF, 16'd0);
    add_sample(-24'sh800000, 15'h7FFF, 16'hFFFF);
    add_sample(24'sh000000, 15'd1000, 16'd8192);
    for (int i = 0; i < 6; i++) add_sample(24'sh7FFFFF, 15'd2000, 16'hFFFF);
    for (int i = 0; i < 6; i++) add_sample(-24'sh800000, 15'd300, 16'hF000);
    add_sample(24'sh400000, 15'h7FFE, 16'd16384);
    add_sample(24'sh000001, 15'h4000, 16'h8000);
    add_sample(-24'sh000001, 15'h2AAA, 16'h5555);
    add_sample(24'sh555555, 15'h5555, 16'hAAAA);
    wait_drained();

    foreach (phases[p]) begin
      write_mode(phases[p]);
      if (p == 8) quiet = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) add_random_sample();
      // long output stall while input keeps coming, to fill the core
      if (p == 2) hold_req = 1'b1;
      wait_drained();
    end

    if (expected_outputs.size() != 0)
      report_mismatch("leftover expectation", '0, expected_outputs[0]);
    $display("checked %0d output samples across all six responses and both null modes",
             checked);
    $display("mismatches: %0d", err_count);
    if (err_count == 0)
      $display("[zdf_ladder_multimode_filter_core] OK");
    else
      $display("[zdf_ladder_multimode_filter_core] ERROR");
    $finish;
  end

endmodule
